// ===== rtl/core/rse_pkg.sv =====
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types, field constants and GF(128) arithmetic for the RS encoder.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int SYM_W      = 7;
    localparam int NPAR       = 5;
    localparam int CNT_W      = 7;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int TDATA_W    = 8;

    localparam logic [SYM_W-1:0] GF_REDUCE = 7'h09;
    localparam logic [SYM_W-1:0] GF_ALPHA  = 7'h02;

    typedef logic [SYM_W-1:0] t_sym;

    // multiply in GF(128), field polynomial x^7+x^3+1
    function automatic t_sym gf_mul(input t_sym a, input t_sym b);
        t_sym x;
        t_sym r;
        x = a;
        r = '0;
        for (int i = 0; i < SYM_W; i++) begin
            if (b[i]) begin
                r = r ^ x;
            end
            x = {x[SYM_W-2:0], 1'b0} ^ (x[SYM_W-1] ? GF_REDUCE : t_sym'(0));
        end
        return r;
    endfunction

    // alpha^n, used only for constants at elaboration
    function automatic t_sym gf_pow(input int n);
        t_sym v;
        v = t_sym'(1);
        for (int i = 0; i < n; i++) begin
            v = gf_mul(v, GF_ALPHA);
        end
        return v;
    endfunction

    localparam t_sym GEN_C0   = gf_pow(52);
    localparam t_sym GEN_C1   = gf_pow(116);
    localparam t_sym GEN_C2   = gf_pow(119);
    localparam t_sym GEN_C3   = gf_pow(61);
    localparam t_sym GEN_C4   = gf_pow(15);
    localparam t_sym EVAL_PT  = gf_pow(6);

    // one queued message symbol; on the last symbol of a block it also
    // carries the final remainder and the partial evaluation
    typedef struct packed {
        t_sym            sym;
        logic            last;
        t_sym [NPAR-1:0] rem;
        t_sym            acc;
    } t_entry;

endpackage

// ===== rtl/core/rse_front.sv =====
// ----------------------------------------------------------------------------
// rse_front
// Accepts message symbols, runs the division register and the evaluation
// accumulator, and marks the last symbol of each block.
// ----------------------------------------------------------------------------
module rse_front #(
    parameter int MSG_LEN = 122
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  rse_pkg::t_sym        i_sym,
    input  logic                 i_full,
    output logic                 o_ready,
    output logic                 o_push,
    output rse_pkg::t_entry      o_entry
);
    import rse_pkg::*;

    t_sym [NPAR-1:0] r_rem;
    t_sym [NPAR-1:0] n_rem;
    t_sym            r_acc;
    t_sym            n_acc;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W:0]   w_count_inc;
    logic             w_last;
    t_sym             w_fb;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        w_fb        = i_sym ^ r_rem[0];
        n_rem[0]    = r_rem[1] ^ gf_mul(w_fb, GEN_C0);
        n_rem[1]    = r_rem[2] ^ gf_mul(w_fb, GEN_C1);
        n_rem[2]    = r_rem[3] ^ gf_mul(w_fb, GEN_C2);
        n_rem[3]    = r_rem[4] ^ gf_mul(w_fb, GEN_C3);
        n_rem[4]    = gf_mul(w_fb, GEN_C4);
        n_acc       = gf_mul(r_acc, EVAL_PT) ^ i_sym;
        w_count_inc = {1'b0, r_count} + (CNT_W+1)'(1);
        w_last      = (w_count_inc >= (CNT_W+1)'(MSG_LEN));
    end

    always_comb begin
        o_entry.sym  = i_sym;
        o_entry.last = w_last;
        o_entry.rem  = n_rem;
        o_entry.acc  = n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_acc   <= '0;
            r_count <= '0;
        end else if (o_push) begin
            if (w_last) begin
                r_rem   <= '0;
                r_acc   <= '0;
                r_count <= '0;
            end else begin
                r_rem   <= n_rem;
                r_acc   <= n_acc;
                r_count <= w_count_inc[CNT_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/core/rse_fifo.sv =====
// ----------------------------------------------------------------------------
// rse_fifo
// Short queue of symbol entries between the front and the back end.
// ----------------------------------------------------------------------------
module rse_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rse_pkg::t_entry  i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output rse_pkg::t_entry  o_entry
);
    import rse_pkg::*;

    t_entry             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (FIFO_AW+1)'(1);
                2'b01:   r_count <= r_count - (FIFO_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/rse_back.sv =====
// ----------------------------------------------------------------------------
// rse_back
// Drains queued entries into the output register: echoes each message
// symbol and, after the last one, the parity symbols and extended check.
// ----------------------------------------------------------------------------
module rse_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  rse_pkg::t_entry  i_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output rse_pkg::t_sym    o_sym,
    output logic             o_is_check,
    output logic             o_block_end
);
    import rse_pkg::*;

    localparam int PH_W = $clog2(NPAR + 1);

    t_sym [NPAR-1:0] r_rem;
    t_sym            r_acc;
    logic [PH_W-1:0] r_phase;
    logic            r_busy;
    logic            r_valid;
    t_sym            r_sym;
    logic            r_is_check;
    logic            r_block_end;
    logic            w_load;
    logic            w_check_now;

    assign w_load      = !r_valid || i_ready;
    assign o_pop       = w_load && !r_busy && !i_empty;
    assign w_check_now = (r_phase == PH_W'(NPAR));

    assign o_valid     = r_valid;
    assign o_sym       = r_sym;
    assign o_is_check  = r_is_check;
    assign o_block_end = r_block_end;

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_busy) begin
                r_is_check <= 1'b1;
                if (w_check_now) begin
                    r_sym       <= r_acc;
                    r_block_end <= 1'b1;
                end else begin
                    r_sym       <= r_rem[0];
                    r_block_end <= 1'b0;
                    r_acc       <= gf_mul(r_acc, EVAL_PT) ^ r_rem[0];
                    for (int k = 0; k < NPAR - 1; k++) begin
                        r_rem[k] <= r_rem[k+1];
                    end
                    r_rem[NPAR-1] <= '0;
                end
            end else if (!i_empty) begin
                r_sym       <= i_entry.sym;
                r_is_check  <= 1'b0;
                r_block_end <= 1'b0;
                r_rem       <= i_entry.rem;
                r_acc       <= i_entry.acc;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_phase <= '0;
        end else if (w_load) begin
            if (r_busy) begin
                r_valid <= 1'b1;
                if (w_check_now) begin
                    r_busy  <= 1'b0;
                    r_phase <= '0;
                end else begin
                    r_phase <= r_phase + PH_W'(1);
                end
            end else if (!i_empty) begin
                r_valid <= 1'b1;
                r_busy  <= i_entry.last;
                r_phase <= '0;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/rs_128_122_gf128_encoder.sv =====
// ----------------------------------------------------------------------------
// rs_128_122_gf128_encoder
// Systematic RS(128,122) encoder over GF(128) with extended check symbol.
// ----------------------------------------------------------------------------
// a message echo is written into the queue when its input transaction is accepted, and
//   is then loaded from the queue into the output register
// throughput: one output symbol per cycle while i_m_axis_tready is high and entries are queued;
//   a block of MSG_LEN echoes is followed by the six check symbols, also one per cycle
// at full rate the 4-entry queue takes three more symbols during the parity drain,
//   then the input stalls; sustained input is MSG_LEN symbols per MSG_LEN + 6 output symbols
// reset: synchronous active-low i_rst_n clears the queue, counters and state
module rs_128_122_gf128_encoder #(
    parameter int MSG_LEN = 122
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [6:0] msg_symbol
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [6:0] code_symbol
    output logic       o_m_axis_tuser,   // [0] is_check
    output logic       o_m_axis_tlast    // block_end
);
    import rse_pkg::*;

    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;
    t_entry w_push_entry;
    t_entry w_head_entry;
    t_sym   w_out_sym;

    rse_front #(
        .MSG_LEN (MSG_LEN)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_sym   (i_s_axis_tdata[SYM_W-1:0]),
        .i_full  (w_full),
        .o_ready (o_s_axis_tready),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    rse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_entry (w_head_entry)
    );

    rse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_entry     (w_head_entry),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_sym       (w_out_sym),
        .o_is_check  (o_m_axis_tuser),
        .o_block_end (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(TDATA_W-SYM_W){1'b0}}, w_out_sym};

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the GF(128) RS(128,122) encoder with extended check.
// A local model of the division register and the evaluation at alpha^6
// predicts every codeword symbol. Symbols are sent in whole blocks while both
// stream sides stall at random, but for a full-rate last part. Each output transaction is then compared
// with the oldest predicted symbol.
// ----------------------------------------------------------------------------
module tb_top;

    import rse_pkg::*;

    localparam int BLOCK_LEN   = 122;
    localparam int PARITY_SYMS = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [6:0] FIELD_REDUCE = 7'h09;

    typedef struct {
        logic [6:0] sym;
        logic       is_check;
        logic       block_end;
    } t_code_symbol;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;    // [6:0] msg_symbol
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;    // [6:0] code_symbol
    logic       o_m_axis_tuser;    // [0] is_check
    logic       o_m_axis_tlast;    // block_end

    // encoder model state
    logic [6:0] parity_regs [PARITY_SYMS];
    logic [6:0] eval_acc;
    logic [6:0] msg_count;
    logic [6:0] gen_poly_coef [PARITY_SYMS];
    logic [6:0] eval_point;

    t_code_symbol expected_codeword[$];
    int           error_count;
    int           cycle_count;
    int           send_idle_pct;
    int           recv_idle_pct;

    rs_128_122_gf128_encoder #(
        .MSG_LEN(BLOCK_LEN)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // horner-style product, high bit of b first
    function automatic logic [6:0] gf128_mul(input logic [6:0] a, input logic [6:0] b);
        logic [6:0] r;
        r = '0;
        for (int i = 6; i >= 0; i--) begin
            r = {r[5:0], 1'b0} ^ (r[6] ? FIELD_REDUCE : 7'h00);
            if (b[i]) begin
                r = r ^ a;
            end
        end
        return r;
    endfunction

    function automatic logic [6:0] alpha_pow(input int n);
        logic [6:0] v;
        v = 7'h01;
        repeat (n) v = gf128_mul(v, 7'h02);
        return v;
    endfunction

    function automatic void clear_encoder_model();
        foreach (parity_regs[k]) parity_regs[k] = '0;
        eval_acc  = '0;
        msg_count = '0;
    endfunction

    // advance the model by one message symbol and queue the codeword symbols
    function automatic void encode_symbol(input logic [6:0] sym);
        logic [6:0] fb;
        expected_codeword.push_back('{sym, 1'b0, 1'b0});
        eval_acc = gf128_mul(eval_acc, eval_point) ^ sym;
        fb = sym ^ parity_regs[0];
        for (int k = 0; k < PARITY_SYMS - 1; k++) begin
            parity_regs[k] = parity_regs[k+1] ^ gf128_mul(fb, gen_poly_coef[k]);
        end
        parity_regs[PARITY_SYMS-1] = gf128_mul(fb, gen_poly_coef[PARITY_SYMS-1]);
        msg_count = msg_count + 7'd1;
        if (msg_count >= 7'(BLOCK_LEN)) begin
            for (int k = 0; k < PARITY_SYMS; k++) begin
                expected_codeword.push_back('{parity_regs[k], 1'b1, 1'b0});
                eval_acc = gf128_mul(eval_acc, eval_point) ^ parity_regs[k];
            end
            expected_codeword.push_back('{eval_acc, 1'b1, 1'b1});
            clear_encoder_model();
        end
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_symbol(input logic [6:0] sym);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, sym};
        do @(posedge i_clk); while (!o_s_axis_tready);
        encode_symbol(sym);
        @(negedge i_clk);
    endtask

    task automatic send_random_symbols(input int count);
        logic [6:0] sym;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(7))
                0: sym = 7'h00;
                1: sym = 7'h7F;
                default: sym = 7'($urandom_range(127));
            endcase
            send_symbol(sym);
        end
    endtask

    task automatic test_extreme_symbols();
        logic [6:0] pattern [25] = '{7'h00, 7'h7F, 7'h01, 7'h02, 7'h04, 7'h08, 7'h10,
                                    7'h20, 7'h40, 7'h7E, 7'h7D, 7'h7B, 7'h77, 7'h6F,
                                    7'h5F, 7'h3F, 7'h55, 7'h2A, 7'h00, 7'h00, 7'h7F,
                                    7'h7F, 7'h7F, 7'h00, 7'h7F};
        send_idle_pct = 26;
        recv_idle_pct = 80;
        foreach (pattern[n]) send_symbol(pattern[n]);
    endtask

    // first block closes here, with the output side mostly stalled
    task automatic test_output_backpressure();
        send_idle_pct = 26;
        recv_idle_pct = 80;
        send_random_symbols(114);
    endtask

    // second block closes here, with a sparse input stream
    task automatic test_sparse_input();
        send_idle_pct = 80;
        recv_idle_pct = 26;
        send_random_symbols(114);
    endtask

    // third block closes at full rate on both sides
    task automatic test_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_symbols(113);
    endtask

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each output transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_code_symbol exp_sym;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_codeword.size() == 0) begin
                error_count++;
                $display("%0t: unexpected symbol, expected none, actual %h chk %b end %b",
                         $time, o_m_axis_tdata[6:0], o_m_axis_tuser, o_m_axis_tlast);
            end else begin
                exp_sym = expected_codeword.pop_front();
                if (o_m_axis_tdata[6:0] !== exp_sym.sym) begin
                    error_count++;
                    $display("%0t: code_symbol expected %h actual %h",
                             $time, exp_sym.sym, o_m_axis_tdata[6:0]);
                end
                if (o_m_axis_tuser !== exp_sym.is_check) begin
                    error_count++;
                    $display("%0t: is_check expected %b actual %b",
                             $time, exp_sym.is_check, o_m_axis_tuser);
                end
                if (o_m_axis_tlast !== exp_sym.block_end) begin
                    error_count++;
                    $display("%0t: block_end expected %b actual %b",
                             $time, exp_sym.block_end, o_m_axis_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        error_count     = 0;
        cycle_count     = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        gen_poly_coef   = '{alpha_pow(52), alpha_pow(116), alpha_pow(119),
                            alpha_pow(61), alpha_pow(15)};
        eval_point      = alpha_pow(6);
        clear_encoder_model();

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_extreme_symbols();
        test_output_backpressure();
        test_sparse_input();
        test_full_rate();
        i_s_axis_tvalid <= 1'b0;

        while (expected_codeword.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
